// ===== design/lct_pkg.sv =====
`default_nettype none

package lct_pkg;

    localparam int unsigned LCT_CAPACITY   = 16;
    localparam int unsigned LCT_COUNT_BITS = 16;
    localparam int unsigned CFG_BITS       = 5;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_rsp;

endpackage

`default_nettype wire

// ===== design/lfu_cache_table.sv =====
// A request is accepted only while idle (o_stall low). The search token must walk the
// whole row of entry cells before the update, and the result must then leave S_OUT
// before the next request is taken; an i_stall holds it there.
// Reset (synchronous, active low) empties the cache, clears occupancy and sets
// capacity_in_use to 16; no clearing pass is needed.
`default_nettype none

module lfu_cache_table
    import lct_pkg::*;
#(
    parameter int unsigned CAPACITY   = LCT_CAPACITY,
    parameter int unsigned COUNT_BITS = LCT_COUNT_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire t_req                i_req,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output t_rsp                     o_rsp,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_BITS-1:0] i_cfg_data
);

    localparam int unsigned IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned OCC_BITS = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_BITS = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          r_state;
    logic                r_start;
    t_req                r_req;
    logic [CFG_BITS-1:0] r_cfg;
    logic [OCC_BITS-1:0] r_occ;

    // The search token runs through the row of cells, one cell per cycle.
    // Element g is the input of cell g; element CAPACITY is the final token.
    logic                  tv    [CAPACITY+1];
    logic                  thit  [CAPACITY+1];
    logic [IDX_BITS-1:0]   thidx [CAPACITY+1];
    logic [IDX_BITS-1:0]   thrank[CAPACITY+1];
    logic [31:0]           thval [CAPACITY+1];
    logic                  tvok  [CAPACITY+1];
    logic [IDX_BITS-1:0]   tvidx [CAPACITY+1];
    logic [COUNT_BITS-1:0] tvcnt [CAPACITY+1];
    logic [IDX_BITS-1:0]   tvrank[CAPACITY+1];
    logic [31:0]           tvkey [CAPACITY+1];
    logic                  tfok  [CAPACITY+1];
    logic [IDX_BITS-1:0]   tfidx [CAPACITY+1];

    logic                touch, wr_val, ins, evict;
    logic [IDX_BITS-1:0] sidx;
    logic [CMP_BITS-1:0] cap_w, cfg_w;
    logic                done;
    t_rsp                n_rsp;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == S_OUT);

    // The head of the row sees an empty token that is launched once per request.
    assign tv[0]     = r_start;
    assign thit[0]   = 1'b0;
    assign thidx[0]  = '0;
    assign thrank[0] = '0;
    assign thval[0]  = '0;
    assign tvok[0]   = 1'b0;
    assign tvidx[0]  = '0;
    assign tvcnt[0]  = '0;
    assign tvrank[0] = '0;
    assign tvkey[0]  = '0;
    assign tfok[0]   = 1'b0;
    assign tfidx[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            lct_cell #(
                .CAPACITY  (CAPACITY),
                .COUNT_BITS(COUNT_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDX_BITS'(g)),
                .i_key   (r_req.key),
                .i_value (r_req.value),
                .i_tv    (tv[g]),
                .i_hit   (thit[g]),
                .i_hidx  (thidx[g]),
                .i_hrank (thrank[g]),
                .i_hval  (thval[g]),
                .i_vok   (tvok[g]),
                .i_vidx  (tvidx[g]),
                .i_vcnt  (tvcnt[g]),
                .i_vrank (tvrank[g]),
                .i_vkey  (tvkey[g]),
                .i_fok   (tfok[g]),
                .i_fidx  (tfidx[g]),
                .o_tv    (tv[g+1]),
                .o_hit   (thit[g+1]),
                .o_hidx  (thidx[g+1]),
                .o_hrank (thrank[g+1]),
                .o_hval  (thval[g+1]),
                .o_vok   (tvok[g+1]),
                .o_vidx  (tvidx[g+1]),
                .o_vcnt  (tvcnt[g+1]),
                .o_vrank (tvrank[g+1]),
                .o_vkey  (tvkey[g+1]),
                .o_fok   (tfok[g+1]),
                .o_fidx  (tfidx[g+1]),
                .i_touch (touch),
                .i_wr_val(wr_val),
                .i_tidx  (thidx[CAPACITY]),
                .i_trank (thrank[CAPACITY]),
                .i_ins   (ins),
                .i_evict (evict),
                .i_sidx  (sidx),
                .i_uvidx (tvidx[CAPACITY]),
                .i_uvrank(tvrank[CAPACITY])
            );
        end
    endgenerate

    // A capacity register above the number of cells acts as the full row.
    assign cfg_w = CMP_BITS'(r_cfg);
    assign cap_w = (cfg_w > CMP_BITS'(CAPACITY)) ? CMP_BITS'(CAPACITY) : cfg_w;

    // When the token leaves the last cell, it carries the hit, the victim and the
    // lowest free slot; the update is broadcast to all cells in that cycle.
    always_comb begin
        done   = (r_state == S_SCAN) && tv[CAPACITY];
        touch  = 1'b0;
        wr_val = 1'b0;
        ins    = 1'b0;
        evict  = 1'b0;
        sidx   = tfidx[CAPACITY];
        n_rsp  = '0;
        n_rsp.hit = thit[CAPACITY];
        if (done) begin
            if (r_req.command == CMD_GET) begin
                touch = thit[CAPACITY];
                n_rsp.read_value = thit[CAPACITY] ? thval[CAPACITY] : 32'd0;
            end else if (cap_w != '0) begin
                if (thit[CAPACITY]) begin
                    touch  = 1'b1;
                    wr_val = 1'b1;
                end else begin
                    evict = (CMP_BITS'(r_occ) >= cap_w) && tvok[CAPACITY];
                    // After an eviction the new entry takes the lower of the
                    // victim's slot and the first slot that was already free.
                    if (evict) begin
                        ins = 1'b1;
                        if (!tfok[CAPACITY] || (tvidx[CAPACITY] < tfidx[CAPACITY])) begin
                            sidx = tvidx[CAPACITY];
                        end
                    end else begin
                        ins = tfok[CAPACITY];
                    end
                    n_rsp.evicted     = evict;
                    n_rsp.evicted_key = evict ? tvkey[CAPACITY] : 32'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_cfg   <= CFG_RESET;
            r_occ   <= '0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SCAN;
                        r_start <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (done) begin
                        r_state <= S_OUT;
                        if (ins && !evict) begin
                            r_occ <= r_occ + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_req <= i_req;
        end
        if (done) begin
            o_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

// ===== design/lct_cell.sv =====
`default_nettype none

module lct_cell
    import lct_pkg::*;
#(
    parameter int unsigned CAPACITY   = LCT_CAPACITY,
    parameter int unsigned COUNT_BITS = LCT_COUNT_BITS,
    localparam int unsigned IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IDX_BITS-1:0]   i_idx,
    input  wire logic [31:0]           i_key,
    input  wire logic [31:0]           i_value,
    // Search token from the left neighbor.
    input  wire logic                  i_tv,
    input  wire logic                  i_hit,
    input  wire logic [IDX_BITS-1:0]   i_hidx,
    input  wire logic [IDX_BITS-1:0]   i_hrank,
    input  wire logic [31:0]           i_hval,
    input  wire logic                  i_vok,
    input  wire logic [IDX_BITS-1:0]   i_vidx,
    input  wire logic [COUNT_BITS-1:0] i_vcnt,
    input  wire logic [IDX_BITS-1:0]   i_vrank,
    input  wire logic [31:0]           i_vkey,
    input  wire logic                  i_fok,
    input  wire logic [IDX_BITS-1:0]   i_fidx,
    // Search token to the right neighbor.
    output logic                       o_tv,
    output logic                       o_hit,
    output logic [IDX_BITS-1:0]        o_hidx,
    output logic [IDX_BITS-1:0]        o_hrank,
    output logic [31:0]                o_hval,
    output logic                       o_vok,
    output logic [IDX_BITS-1:0]        o_vidx,
    output logic [COUNT_BITS-1:0]      o_vcnt,
    output logic [IDX_BITS-1:0]        o_vrank,
    output logic [31:0]                o_vkey,
    output logic                       o_fok,
    output logic [IDX_BITS-1:0]        o_fidx,
    // Update broadcast.
    input  wire logic                  i_touch,
    input  wire logic                  i_wr_val,
    input  wire logic [IDX_BITS-1:0]   i_tidx,
    input  wire logic [IDX_BITS-1:0]   i_trank,
    input  wire logic                  i_ins,
    input  wire logic                  i_evict,
    input  wire logic [IDX_BITS-1:0]   i_sidx,
    input  wire logic [IDX_BITS-1:0]   i_uvidx,
    input  wire logic [IDX_BITS-1:0]   i_uvrank
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  r_valid;
    logic [31:0]           r_key;
    logic [31:0]           r_val;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [IDX_BITS-1:0]   r_rank;
    logic                  n_take_v;
    logic                  n_take_h;
    logic                  n_take_f;
    logic [IDX_BITS-1:0]   n_rank_dec;

    assign n_take_h = r_valid && (r_key == i_key) && !i_hit;
    assign n_take_v = r_valid && (!i_vok || (r_cnt < i_vcnt) ||
                      ((r_cnt == i_vcnt) && (r_rank > i_vrank)));
    assign n_take_f = !r_valid && !i_fok;
    assign n_rank_dec = (i_evict && (r_rank > i_uvrank)) ? r_rank - 1'b1 : r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tv <= 1'b0;
        end else begin
            o_tv <= i_tv;
        end
        o_hit   <= i_hit || n_take_h;
        o_hidx  <= n_take_h ? i_idx : i_hidx;
        o_hrank <= n_take_h ? r_rank : i_hrank;
        o_hval  <= n_take_h ? r_val : i_hval;
        o_vok   <= i_vok || n_take_v;
        o_vidx  <= n_take_v ? i_idx : i_vidx;
        o_vcnt  <= n_take_v ? r_cnt : i_vcnt;
        o_vrank <= n_take_v ? r_rank : i_vrank;
        o_vkey  <= n_take_v ? r_key : i_vkey;
        o_fok   <= i_fok || n_take_f;
        o_fidx  <= n_take_f ? i_idx : i_fidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ins) begin
            if (i_idx == i_sidx) begin
                r_valid <= 1'b1;
            end else if (i_evict && (i_idx == i_uvidx)) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_touch) begin
            if (i_idx == i_tidx) begin
                if (r_cnt != CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_rank <= '0;
                if (i_wr_val) begin
                    r_val <= i_value;
                end
            end else if (r_valid && (r_rank < i_trank)) begin
                r_rank <= r_rank + 1'b1;
            end
        end else if (i_ins) begin
            if (i_idx == i_sidx) begin
                r_key  <= i_key;
                r_val  <= i_value;
                r_cnt  <= '0;
                r_rank <= '0;
            end else if (r_valid && !(i_evict && (i_idx == i_uvidx))) begin
                r_rank <= n_rank_dec + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
